### rtl/core/bpc_pkg.sv
// bpc_pkg: shared constants, codes and types of the button press classifier
// no dependencies; used by every other file of the block
package bpc_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int BTN_W       = 2;
	localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int TIME_W      = 32;
	localparam int LONG_W      = 27;
	localparam int DEB_W       = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_SLACK  = 4;

	localparam logic [ADDR_W-1:0] LAST_BTN = ADDR_W'(NUM_BUTTONS - 1);

	localparam logic [LONG_W-1:0] LONG_RESET = LONG_W'(1000000);
	localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(50000);

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(1);

	localparam logic KIND_PIN   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;
	localparam logic LEVEL_LOW  = 1'b0;

	typedef enum logic [1:0] {
		EV_PRESSED  = 2'd0,
		EV_RELEASED = 2'd1,
		EV_SHORT    = 2'd2,
		EV_LONG     = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic              pressed;
		logic              long_rep;
		logic [TIME_W-1:0] press_start;
		logic [TIME_W-1:0] release_stamp;
	} st_entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		st_entry_t         wr_data;
	} ram_req_t;

	typedef struct packed {
		event_kind_t      event_kind;
		logic [BTN_W-1:0] event_button;
		logic             last_of_run;
	} evt_word_t;

	typedef struct packed {
		logic [1:0] cnt;
		evt_word_t  w0;
		evt_word_t  w1;
	} evt_push_t;

endpackage

### rtl/core/bpc_in_if.sv
// bpc_in_if: input item channel (pin change or long-press check)
// depends on bpc_pkg
interface bpc_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [bpc_pkg::BTN_W-1:0]    button;
	logic                         level;
	logic [bpc_pkg::TIME_W-1:0]   now_us;

	modport source (output valid, kind, button, level, now_us, input ready);
	modport sink   (input valid, kind, button, level, now_us, output ready);
endinterface

### rtl/core/bpc_out_if.sv
// bpc_out_if: event channel of the classifier
// depends on bpc_pkg
interface bpc_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                event_kind;
	logic [bpc_pkg::BTN_W-1:0] event_button;
	logic                      last_of_run;

	modport source (output valid, event_kind, event_button, last_of_run, input ready);
	modport sink   (input valid, event_kind, event_button, last_of_run, output ready);
endinterface

### rtl/core/bpc_cfg_if.sv
// bpc_cfg_if: register write channel
// depends on bpc_pkg
interface bpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]  index;
	logic [bpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bpc_state_ram.sv
// bpc_state_ram: per-button state memory, one read and one write port, registered read
// depends on bpc_pkg; entries never written read as zero
module bpc_state_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  bpc_pkg::ram_req_t   req,
	output bpc_pkg::st_entry_t  rd_data
);

	bpc_pkg::st_entry_t                 mem [bpc_pkg::NUM_BUTTONS];
	logic [bpc_pkg::NUM_BUTTONS-1:0]    vld_q;
	bpc_pkg::st_entry_t                 rd_q;
	logic                               rvld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rd_q : '0;

endmodule

### rtl/core/bpc_seq.sv
// bpc_seq: config registers, item issue and check sweep, read-modify-write stage
// depends on bpc_pkg, bpc_in_if, bpc_cfg_if; drives bpc_state_ram and bpc_out_fifo
module bpc_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	bpc_in_if.sink                             item,
	bpc_cfg_if.sink                            cfg,
	input  logic [bpc_pkg::FIFO_CNT_W-1:0]     fifo_cnt,
	output bpc_pkg::ram_req_t                  ram_req,
	input  bpc_pkg::st_entry_t                 ram_rd,
	output bpc_pkg::evt_push_t                 push
);

	logic [bpc_pkg::LONG_W-1:0]  long_q;
	logic [bpc_pkg::DEB_W-1:0]   deb_q;

	logic                        chk_busy_q;
	logic [bpc_pkg::ADDR_W-1:0]  chk_idx_q;
	logic [bpc_pkg::TIME_W-1:0]  chk_now_q;

	logic                        space_ok;
	logic                        item_acc;
	logic                        iss_v;
	logic                        iss_chk;
	logic                        iss_last;
	logic [bpc_pkg::ADDR_W-1:0]  iss_addr;
	logic [bpc_pkg::TIME_W-1:0]  iss_now;
	logic                        iss_level;

	logic                        v_s1;
	logic                        chk_s1;
	logic                        last_s1;
	logic [bpc_pkg::ADDR_W-1:0]  addr_s1;
	logic                        level_s1;
	logic [bpc_pkg::TIME_W-1:0]  now_s1;

	logic                        fwd_v_q;
	logic [bpc_pkg::ADDR_W-1:0]  fwd_addr_q;
	bpc_pkg::st_entry_t          fwd_data_q;

	logic                        hold_v_q;
	logic [bpc_pkg::ADDR_W-1:0]  hold_btn_q;
	logic                        hold_v_nxt;
	logic [bpc_pkg::ADDR_W-1:0]  hold_btn_nxt;

	bpc_pkg::st_entry_t          cur;
	bpc_pkg::st_entry_t          wr_data;
	logic                        wr_en;
	logic [bpc_pkg::TIME_W-1:0]  held_time;
	logic [bpc_pkg::TIME_W-1:0]  since_rel;
	logic                        is_long;
	logic                        debounced;
	logic                        fire;
	logic [bpc_pkg::BTN_W-1:0]   btn;
	logic [bpc_pkg::BTN_W-1:0]   hold_btn;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= bpc_pkg::LONG_RESET;
			deb_q  <= bpc_pkg::DEB_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				bpc_pkg::REG_LONG_PRESS: long_q <= cfg.data[bpc_pkg::LONG_W-1:0];
				bpc_pkg::REG_DEBOUNCE:   deb_q  <= cfg.data[bpc_pkg::DEB_W-1:0];
				default: ;
			endcase
		end
	end

	// issue
	assign space_ok   = fifo_cnt <= bpc_pkg::FIFO_CNT_W'(bpc_pkg::FIFO_DEPTH - bpc_pkg::FIFO_SLACK);
	assign item.ready = !chk_busy_q && space_ok;
	assign item_acc   = item.valid && item.ready;

	always_comb begin
		iss_v     = 1'b0;
		iss_chk   = 1'b0;
		iss_addr  = chk_idx_q;
		iss_last  = (chk_idx_q == bpc_pkg::LAST_BTN);
		iss_now   = chk_now_q;
		iss_level = 1'b0;
		if (chk_busy_q) begin
			iss_v   = space_ok;
			iss_chk = 1'b1;
		end else if (item_acc) begin
			iss_now   = item.now_us;
			iss_level = item.level;
			if (item.kind == bpc_pkg::KIND_CHECK) begin
				iss_v    = 1'b1;
				iss_chk  = 1'b1;
				iss_addr = '0;
				iss_last = (bpc_pkg::LAST_BTN == '0);
			end else begin
				iss_v    = int'(item.button) < bpc_pkg::NUM_BUTTONS;
				iss_addr = bpc_pkg::ADDR_W'(item.button);
				iss_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_busy_q <= 1'b0;
			chk_idx_q  <= '0;
			chk_now_q  <= '0;
		end else if (iss_v && iss_chk) begin
			chk_busy_q <= !iss_last;
			chk_idx_q  <= iss_addr + bpc_pkg::ADDR_W'(1);
			chk_now_q  <= iss_now;
		end
	end

	assign ram_req.rd_en   = iss_v;
	assign ram_req.rd_addr = iss_addr;

	// stage 1: read data arrives, modify and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= iss_v;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_v) begin
			chk_s1   <= iss_chk;
			last_s1  <= iss_last;
			addr_s1  <= iss_addr;
			level_s1 <= iss_level;
			now_s1   <= iss_now;
		end
	end

	// forward the write that landed on the same edge as the read
	assign cur       = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rd;
	assign held_time = now_s1 - cur.press_start;
	assign since_rel = now_s1 - cur.release_stamp;
	assign is_long   = held_time >= bpc_pkg::TIME_W'(long_q);
	assign debounced = since_rel > bpc_pkg::TIME_W'(deb_q);
	assign fire      = cur.pressed && !cur.long_rep && is_long;
	assign btn       = bpc_pkg::BTN_W'(addr_s1);
	assign hold_btn  = bpc_pkg::BTN_W'(hold_btn_q);

	always_comb begin
		wr_en        = 1'b0;
		wr_data      = cur;
		push         = '0;
		hold_v_nxt   = hold_v_q;
		hold_btn_nxt = hold_btn_q;
		if (v_s1) begin
			if (chk_s1) begin
				// a long event waits in the hold register until the sweep shows if it is last
				if (fire) begin
					wr_en            = 1'b1;
					wr_data.long_rep = 1'b1;
					if (last_s1) begin
						if (hold_v_q) begin
							push.cnt = 2'd2;
							push.w0  = '{bpc_pkg::EV_LONG, hold_btn, 1'b0};
							push.w1  = '{bpc_pkg::EV_LONG, btn, 1'b1};
						end else begin
							push.cnt = 2'd1;
							push.w0  = '{bpc_pkg::EV_LONG, btn, 1'b1};
						end
						hold_v_nxt = 1'b0;
					end else begin
						if (hold_v_q) begin
							push.cnt = 2'd1;
							push.w0  = '{bpc_pkg::EV_LONG, hold_btn, 1'b0};
						end
						hold_v_nxt   = 1'b1;
						hold_btn_nxt = addr_s1;
					end
				end else if (last_s1) begin
					if (hold_v_q) begin
						push.cnt = 2'd1;
						push.w0  = '{bpc_pkg::EV_LONG, hold_btn, 1'b1};
					end
					hold_v_nxt = 1'b0;
				end
			end else if (level_s1 == bpc_pkg::LEVEL_LOW) begin
				if (!cur.pressed && debounced) begin
					wr_en               = 1'b1;
					wr_data.pressed     = 1'b1;
					wr_data.long_rep    = 1'b0;
					wr_data.press_start = now_s1;
					push.cnt            = 2'd1;
					push.w0             = '{bpc_pkg::EV_PRESSED, btn, 1'b1};
				end
			end else if (cur.pressed) begin
				wr_en                 = 1'b1;
				wr_data.pressed       = 1'b0;
				wr_data.release_stamp = now_s1;
				if (!cur.long_rep && !is_long) begin
					push.cnt = 2'd2;
					push.w0  = '{bpc_pkg::EV_SHORT, btn, 1'b0};
					push.w1  = '{bpc_pkg::EV_RELEASED, btn, 1'b1};
				end else begin
					push.cnt = 2'd1;
					push.w0  = '{bpc_pkg::EV_RELEASED, btn, 1'b1};
				end
			end
		end
	end

	assign ram_req.wr_en   = wr_en;
	assign ram_req.wr_addr = addr_s1;
	assign ram_req.wr_data = wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			fwd_v_q  <= wr_en;
			hold_v_q <= hold_v_nxt;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wr_data;
		hold_btn_q <= hold_btn_nxt;
	end

endmodule

### rtl/core/bpc_out_fifo.sv
// bpc_out_fifo: event queue, up to two words in and one word out per cycle
// depends on bpc_pkg, bpc_out_if
module bpc_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpc_pkg::evt_push_t              push,
	bpc_out_if.source                       evt,
	output logic [bpc_pkg::FIFO_CNT_W-1:0]  cnt
);

	bpc_pkg::evt_word_t                 mem [bpc_pkg::FIFO_DEPTH];
	logic [bpc_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [bpc_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [bpc_pkg::FIFO_CNT_W-1:0]     cnt_q;
	logic                               pop;
	bpc_pkg::evt_word_t                 head;

	assign pop  = evt.valid && evt.ready;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.w0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_q + bpc_pkg::FIFO_PTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bpc_pkg::FIFO_PTR_W'(push.cnt);
			rd_ptr_q <= rd_ptr_q + bpc_pkg::FIFO_PTR_W'(pop);
			cnt_q    <= cnt_q + bpc_pkg::FIFO_CNT_W'(push.cnt) - bpc_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign cnt              = cnt_q;
	assign evt.valid        = cnt_q != '0;
	assign evt.event_kind   = head.event_kind;
	assign evt.event_button = head.event_button;
	assign evt.last_of_run  = head.last_of_run;

endmodule

### rtl/core/button_press_classifier.sv
// button_press_classifier: top level, debounce and short/long press classification
// depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_if, bpc_state_ram, bpc_seq, bpc_out_fifo
//
//   channel  dir  payload                                   moves a word when
//   item     in   kind, button, level, now_us               valid && ready
//   evt      out  event_kind, event_button, last_of_run     valid && ready
//   cfg      in   index, data                               valid && ready
//
// a pin change is issued as soon as it is taken; a check sweeps the state memory, one button
// per cycle, and holds ready low until the sweep has issued the last button; a sweep step
// also waits for queue space
// events reach evt through stage 1 of bpc_seq and then an eight-word queue
// ready drops while the queue has fewer than four free words
// reset clears all button state at once through per-entry valid bits; no clearing pass
// cfg is always ready; registers reset to 1000000 and 50000
module button_press_classifier (
	input  logic       clk,
	input  logic       arst_n,
	bpc_in_if.sink     item,
	bpc_out_if.source  evt,
	bpc_cfg_if.sink    cfg
);

	bpc_pkg::ram_req_t                  ram_req;
	bpc_pkg::st_entry_t                 ram_rd;
	bpc_pkg::evt_push_t                 push;
	logic [bpc_pkg::FIFO_CNT_W-1:0]     fifo_cnt;

	bpc_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (ram_rd)
	);

	bpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.fifo_cnt (fifo_cnt),
		.ram_req  (ram_req),
		.ram_rd   (ram_rd),
		.push     (push)
	);

	bpc_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.evt    (evt),
		.cnt    (fifo_cnt)
	);

endmodule
